// File: design/lwc_pkg.sv
// Package for the literal search block: field widths, register indexes,
// configuration structs and default parameter values. No dependencies.
package lwc_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 48;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int LEN_W      = 5;
  localparam int CTX_W      = 16;
  localparam int FIELD_W    = 48;
  localparam int CLEN_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_DATA_W = 120;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTX_LEAD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTX_TRAIL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_START = 3'd7;

  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]        pattern_length;
    logic                    every_hit;
  } front_cfg_t;

  typedef struct packed {
    logic [CTX_W-1:0]   ctx_lead;
    logic [CTX_W-1:0]   ctx_trail;
    logic [FIELD_W-1:0] file_size;
    logic [FIELD_W-1:0] interval_start;
  } back_cfg_t;

endpackage

// File: design/lwc_front.sv
// Front end: byte window, literal compare and non-overlapping hit selection (every hit or first hit only).
// Pushes (relative start, length) of each hit to the queue. Uses lwc_pkg.
module lwc_front import lwc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  front_cfg_t                   cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tlast,
  input  logic                         q_ready,
  output logic                         q_push,
  output logic [OFFSET_BITS+LEN_W-1:0] q_data
);

  localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]             win_r [MAX_PATTERN];
  logic [7:0]             win_nxt [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] nas_r, nas_nxt;
  logic                   done_r, done_nxt;

  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       idx;
  logic [OFFSET_BITS-1:0] count;
  logic [OFFSET_BITS-1:0] len_w;
  logic [OFFSET_BITS-1:0] rel;
  logic                   match;
  logic                   hit;
  logic                   accept;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
  end

  always_comb begin
    win_nxt[0] = in_tdata;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_comb begin
    match = 1'b1;
    idx   = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len) begin
        idx = len - LEN_W'(1) - LEN_W'(i);
        if (win_nxt[idx[WIN_IW-1:0]] != cfg.pattern[8*i +: 8]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign count = seen_r + OFFSET_BITS'(1);
  assign len_w = OFFSET_BITS'(len);
  assign rel   = count - len_w;
  assign hit   = match && (count >= len_w) && !(!cfg.every_hit && done_r) && (rel >= nas_r);

  assign q_push = accept && hit;
  assign q_data = {len, rel};

  always_comb begin
    seen_nxt = seen_r;
    nas_nxt  = nas_r;
    done_nxt = done_r;
    if (accept) begin
      seen_nxt = count;
      if (hit) begin
        nas_nxt  = rel + len_w;
        done_nxt = 1'b1;
      end
      if (in_tlast) begin
        seen_nxt = '0;
        nas_nxt  = '0;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      nas_r  <= '0;
      done_r <= 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      nas_r  <= nas_nxt;
      done_r <= done_nxt;
      if (accept) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_r[k] <= in_tlast ? 8'd0 : win_nxt[k];
        end
      end
    end
  end

endmodule

// File: design/lwc_queue.sv
// Small FIFO of hit records between front and back end.
// Register-based, no package dependency beyond default values and LEN_W from lwc_pkg.
module lwc_queue import lwc_pkg::*; #(
  parameter int WIDTH = OFFSET_BITS_DEF + LEN_W,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign ready   = (cnt_r != CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// File: design/lwc_back.sv
// Back end: turns hit records into file offsets and clamped context spans.
// Three arithmetic stages plus the output register. Uses lwc_pkg.
module lwc_back import lwc_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  back_cfg_t                    cfg,
  input  logic                         q_valid,
  input  logic [OFFSET_BITS+LEN_W-1:0] q_head,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_DATA_W-1:0]        out_tdata
);

  localparam int W = OFFSET_BITS;

  logic             adv;
  logic [W-1:0]     q_rel;
  logic [LEN_W-1:0] q_len;

  logic             v1_r;
  logic [W-1:0]     hit1_r;
  logic [LEN_W-1:0] len1_r;

  logic             v2_r;
  logic [W-1:0]     hit2_r, ctx2_r, hend2_r;
  logic [CTX_W-1:0] bef2_r;
  logic [LEN_W-1:0] len2_r;

  logic             v3_r;
  logic [W-1:0]     hit3_r, ctx3_r, room3_r;
  logic [CTX_W-1:0] bef3_r;
  logic [LEN_W-1:0] len3_r;
  logic             gt3_r;

  logic             vo_r;
  logic [W-1:0]     hito_r, ctxo_r;
  logic [CLEN_W-1:0] clen_r;

  logic             bef_lt;
  logic [W-1:0]     fs_w;
  logic [CTX_W-1:0] after;

  assign adv   = !vo_r || out_tready;
  assign q_pop = adv && q_valid;
  assign q_rel = q_head[W-1:0];
  assign q_len = q_head[W +: LEN_W];
  assign fs_w  = W'(cfg.file_size);

  assign bef_lt = hit1_r < W'(cfg.ctx_lead);

  always_comb begin
    after = '0;
    if (gt3_r) begin
      after = (room3_r < W'(cfg.ctx_trail)) ? CTX_W'(room3_r) : cfg.ctx_trail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit1_r  <= W'(cfg.interval_start) + q_rel;
      len1_r  <= q_len;

      hit2_r  <= hit1_r;
      bef2_r  <= bef_lt ? CTX_W'(hit1_r) : cfg.ctx_lead;
      ctx2_r  <= bef_lt ? '0 : hit1_r - W'(cfg.ctx_lead);
      hend2_r <= hit1_r + W'(len1_r);
      len2_r  <= len1_r;

      hit3_r  <= hit2_r;
      ctx3_r  <= ctx2_r;
      bef3_r  <= bef2_r;
      len3_r  <= len2_r;
      gt3_r   <= fs_w > hend2_r;
      room3_r <= fs_w - hend2_r;

      hito_r  <= hit3_r;
      ctxo_r  <= ctx3_r;
      clen_r  <= CLEN_W'(bef3_r) + CLEN_W'(len3_r) + CLEN_W'(after);
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {(OUT_DATA_W - 2*FIELD_W - CLEN_W)'(0), clen_r,
                       FIELD_W'(ctxo_r), FIELD_W'(hito_r)};

endmodule

// File: design/literal_search_with_context.sv
// Top level of the streaming literal search with context spans.
// Holds the configuration registers; instantiates lwc_front, lwc_queue, lwc_back.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tdata[7:0] data_byte, in_tlast last_byte
//  out     | out | out_tvalid/out_tready| out_tdata hit_offset, context_offset, context_length
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One byte per cycle is accepted while the hit queue has room; the window compare
// is combinational. A hit passes the queue, the back-end stages and the output register.
// in_tready drops only while the hit queue is full; out stalls back up the
// back-end pipeline into the queue. Reset is synchronous; cfg_ready is always high.
module literal_search_with_context import lwc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [47:0] hit_offset, [95:48] context_offset,
                                            // [113:96] context_length, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QW = OFFSET_BITS + LEN_W;

  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]      plen_r;
  logic                  every_hit_r;
  logic [CTX_W-1:0]      bbef_r, baft_r;
  logic [FIELD_W-1:0]    fsize_r, istart_r;

  front_cfg_t fcfg;
  back_cfg_t  bcfg;

  logic          q_push, q_ready, q_pop, q_valid;
  logic [QW-1:0] q_wdata, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      plen_r      <= LEN_W'(1);
      every_hit_r <= 1'b0;
      bbef_r      <= '0;
      baft_r      <= '0;
      fsize_r     <= '0;
      istart_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pat_lo_r    <= cfg_data;
        REG_PATTERN_HIGH:   pat_hi_r    <= cfg_data;
        REG_PATTERN_LENGTH: plen_r      <= cfg_data[LEN_W-1:0];
        REG_HIT_MODE:       every_hit_r <= cfg_data[0];
        REG_CTX_LEAD:       bbef_r      <= cfg_data[CTX_W-1:0];
        REG_CTX_TRAIL:      baft_r      <= cfg_data[CTX_W-1:0];
        REG_FILE_SIZE:      fsize_r     <= cfg_data[FIELD_W-1:0];
        REG_INTERVAL_START: istart_r    <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fcfg.pattern        = {pat_hi_r, pat_lo_r};
    fcfg.pattern_length = plen_r;
    fcfg.every_hit      = every_hit_r;
    bcfg.ctx_lead       = bbef_r;
    bcfg.ctx_trail      = baft_r;
    bcfg.file_size      = fsize_r;
    bcfg.interval_start = istart_r;
  end

  lwc_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (fcfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  lwc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  lwc_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (bcfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
